/* hw/rtl/stsu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer slots: shared definitions
// Command codes, controller states, widths and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stsu_pkg;

    // Default number of timer slots.
    localparam int NUM_SLOTS_DEF = 16;

    // Field widths of the stream payloads.
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 32;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Command carried by each input item.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_ADD  = 2'd2,
        OP_DEL  = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FLUSH
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic apply;       // execute a set, add or delete command
        logic walk_start;  // begin a tick walk at slot zero
        logic walk_step;   // update the current slot and read the next one
        logic flush;       // hand the held expiry to the output as the last one
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic stall;       // an expiry cannot be placed because the output is full
        logic idx_last;    // the walk sits on the highest slot
        logic flush_ok;    // the final expiry can be handed off
    } status_t;

endpackage
`default_nettype wire

/* hw/rtl/stsu_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer slots: datapath
// Holds the slot table, applies commands, walks the slots on a tick and
// keeps one expiry pending so the final one of a tick can be marked.
// ----------------------------------------------------------------------------
module stsu_datapath #(
    parameter int NUM_SLOTS = stsu_pkg::NUM_SLOTS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  stsu_pkg::cmd_t               cmd,
    output stsu_pkg::status_t            stat,
    input  wire  [1:0]                   in_op,
    input  wire  [stsu_pkg::SLOT_W-1:0]  in_slot,
    input  wire  [stsu_pkg::CNT_W-1:0]   in_interval,
    input  wire                          in_repeat,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [stsu_pkg::SLOT_W-1:0]  out_slot,
    output logic                         out_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Slot table: flags in flip-flops, counts and reloads in memories.
    logic [NUM_SLOTS-1:0]         active_reg;
    logic [NUM_SLOTS-1:0]         wvld_reg;
    logic [stsu_pkg::CNT_W-1:0]   count_mem  [0:NUM_SLOTS-1];
    logic [stsu_pkg::CNT_W-1:0]   reload_mem [0:NUM_SLOTS-1];

    logic [stsu_pkg::CNT_W-1:0]   rd_cnt_reg;
    logic [stsu_pkg::CNT_W-1:0]   rd_rld_reg;
    logic                         rd_vld_reg;
    logic [IW-1:0]                idx_reg;

    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    logic [stsu_pkg::SLOT_W-1:0]  pend_slot_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [stsu_pkg::SLOT_W-1:0]  out_slot_reg;
    logic                         out_last_reg;

    logic                         slot_ok;
    logic [IW-1:0]                slot_idx;
    logic [stsu_pkg::CNT_W-1:0]   cur_cnt;
    logic [stsu_pkg::CNT_W-1:0]   cur_rld;
    logic [stsu_pkg::CNT_W-1:0]   dec_cnt;
    logic                         cur_active;
    logic                         fire;
    logic                         out_free;
    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic                         set_we;
    logic                         walk_we;
    logic                         mem_we;
    logic [IW-1:0]                wr_addr;
    logic [stsu_pkg::CNT_W-1:0]   wr_cnt;
    logic [stsu_pkg::CNT_W-1:0]   wr_rld;
    logic                         out_load;
    logic                         out_load_last;

    // Command decode for the addressed slot.
    assign slot_ok  = {3'b000, in_slot} < 7'(NUM_SLOTS);
    assign slot_idx = IW'(in_slot);
    assign set_we   = cmd.apply && (stsu_pkg::op_t'(in_op) == stsu_pkg::OP_SET) && slot_ok
                      && !active_reg[slot_idx];

    // Current slot of the walk; entries never written read as zero.
    assign cur_cnt    = rd_vld_reg ? rd_cnt_reg : '0;
    assign cur_rld    = rd_vld_reg ? rd_rld_reg : '0;
    assign dec_cnt    = cur_cnt - 32'd1;
    assign cur_active = active_reg[idx_reg];
    assign fire       = cur_active && (dec_cnt == '0);
    assign walk_we    = cmd.walk_step && cur_active;

    // Output register is free when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    assign stat.stall    = fire && pend_valid_reg && !out_free;
    assign stat.idx_last = (idx_reg == IW'(NUM_SLOTS - 1));
    assign stat.flush_ok = !pend_valid_reg || out_free;

    // Read port: slot zero on start, otherwise one ahead of the walk.
    assign rd_en   = cmd.walk_start || cmd.walk_step;
    assign rd_addr = cmd.walk_start ? '0 : IW'(idx_reg + IW'(1));

    // Write port: set command or walk write-back.
    assign mem_we  = set_we || walk_we;
    assign wr_addr = cmd.apply ? slot_idx : idx_reg;
    assign wr_cnt  = set_we ? in_interval
                   : ((fire && (cur_rld != '0)) ? cur_rld : dec_cnt);
    assign wr_rld  = set_we ? (in_repeat ? in_interval : '0) : cur_rld;

    // Count and reload memories with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            count_mem[wr_addr]  <= wr_cnt;
            reload_mem[wr_addr] <= wr_rld;
        end
        if (rd_en) begin
            rd_cnt_reg <= count_mem[rd_addr];
            rd_rld_reg <= reload_mem[rd_addr];
        end
    end

    // Active flags, written flags and the walk index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            wvld_reg   <= '0;
            rd_vld_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (mem_we) begin
                wvld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= wvld_reg[rd_addr];
            end
            if (cmd.walk_start) begin
                idx_reg <= '0;
            end else if (cmd.walk_step) begin
                idx_reg <= IW'(idx_reg + IW'(1));
            end
            if (cmd.apply && slot_ok) begin
                unique case (stsu_pkg::op_t'(in_op))
                    stsu_pkg::OP_ADD: active_reg[slot_idx] <= 1'b1;
                    stsu_pkg::OP_DEL: active_reg[slot_idx] <= 1'b0;
                    stsu_pkg::OP_TICK,
                    stsu_pkg::OP_SET: ;
                endcase
            end else if (walk_we && fire && (cur_rld == '0)) begin
                active_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Expiry hand-off: a new expiry pushes the pending one out as not last.
    always_comb begin
        out_load      = 1'b0;
        out_load_last = 1'b0;
        pend_valid_next = pend_valid_reg;
        if (cmd.walk_step && fire) begin
            out_load        = pend_valid_reg;
            pend_valid_next = 1'b1;
        end else if (cmd.flush && pend_valid_reg) begin
            out_load        = 1'b1;
            out_load_last   = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control bits of the pending and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the pending and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.walk_step && fire) begin
            pend_slot_reg <= stsu_pkg::SLOT_W'(idx_reg);
        end
        if (out_load) begin
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= out_load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A pending expiry is only pushed out into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk_step && fire && pend_valid_reg) |-> out_free)
        else $error("expiry pushed into a full output register");

    // The final expiry is handed off only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush && pend_valid_reg) |-> out_free)
        else $error("final expiry handed into a full output register");

    // After the flush nothing remains pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> !pend_valid_reg)
        else $error("expiry left pending after a tick");

    // Commands outside a walk never meet a pending expiry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply || cmd.walk_start) |-> !pend_valid_reg)
        else $error("pending expiry outside of a tick walk");
`endif

endmodule
`default_nettype wire

/* hw/rtl/stsu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer slots: controller
// Accepts commands in idle, sequences the slot walk of a tick and the
// hand-off of the last expiry.
// ----------------------------------------------------------------------------
module stsu_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [1:0]         in_op,
    output stsu_pkg::cmd_t     cmd,
    input  stsu_pkg::status_t  stat
);

    stsu_pkg::state_t state_reg;
    stsu_pkg::state_t state_next;
    logic             is_tick;

    assign is_tick = (stsu_pkg::op_t'(in_op) == stsu_pkg::OP_TICK);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stsu_pkg::ST_IDLE: begin
                if (in_valid && is_tick) begin
                    state_next = stsu_pkg::ST_UPDATE;
                end
            end
            stsu_pkg::ST_UPDATE: begin
                if (!stat.stall && stat.idx_last) begin
                    state_next = stsu_pkg::ST_FLUSH;
                end
            end
            stsu_pkg::ST_FLUSH: begin
                if (stat.flush_ok) begin
                    state_next = stsu_pkg::ST_IDLE;
                end
            end
            default: state_next = stsu_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        in_ready       = 1'b0;
        cmd.apply      = 1'b0;
        cmd.walk_start = 1'b0;
        cmd.walk_step  = 1'b0;
        cmd.flush      = 1'b0;
        unique case (state_reg)
            stsu_pkg::ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.apply      = in_valid && !is_tick;
                cmd.walk_start = in_valid && is_tick;
            end
            stsu_pkg::ST_UPDATE: cmd.walk_step = !stat.stall;
            stsu_pkg::ST_FLUSH:  cmd.flush     = stat.flush_ok;
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stsu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A tick always enters the walk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_start |=> (state_reg == stsu_pkg::ST_UPDATE))
        else $error("tick did not start a walk");

    // No slot is stepped while the walk is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.stall |-> !cmd.walk_step)
        else $error("slot stepped during a stall");

    // Items are taken only in idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply || cmd.walk_start) |-> (state_reg == stsu_pkg::ST_IDLE))
        else $error("command taken outside of idle");
`endif

endmodule
`default_nettype wire

/* hw/rtl/software_timer_slots_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer slots unit
// A table of one-shot and periodic timer slots driven by set, activate,
// delete and tick commands; each tick reports the slots that expired.
// ----------------------------------------------------------------------------
// Set, activate and delete are applied as they are taken in idle. A tick walks
// the slots one per cycle through the one read port and one write port of the
// count and reload memories, pausing only while the result channel is held off
// with expiries waiting, and holds off new items until it is done. Expiries
// come out in ascending slot order, the final one of a tick with tlast set; a
// new item is taken while the last result still waits to be taken.
module software_timer_slots_unit #(
    parameter int NUM_SLOTS = stsu_pkg::NUM_SLOTS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [stsu_pkg::S_TDATA_W-1:0]    s_tdata,  // slot[3:0], interval[35:4],
                                                        // repeat_req[36], zero fill
    input  wire  [stsu_pkg::S_TUSER_W-1:0]    s_tuser,  // operation[1:0]
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [stsu_pkg::M_TDATA_W-1:0]    m_tdata,  // fired_slot[3:0], zero fill
    output logic                              m_tlast   // last_of_tick
);

    stsu_pkg::cmd_t               cmd;
    stsu_pkg::status_t            stat;
    logic [stsu_pkg::SLOT_W-1:0]  out_slot;

    // Command sequencing.
    stsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser[1:0]),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Slot table and expiry reporting.
    stsu_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_tuser[1:0]),
        .in_slot     (s_tdata[3:0]),
        .in_interval (s_tdata[35:4]),
        .in_repeat   (s_tdata[36]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_slot    (out_slot),
        .out_last    (m_tlast)
    );

    assign m_tdata = {4'b0000, out_slot};

endmodule
`default_nettype wire

/* test/tb_software_timer_slots_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer slots unit: self-checking testbench
// Drives set, activate, delete and tick commands into the stream input and
// checks every expiry that the unit reports against a behavioral model of
// the slot table. The run covers directed corner cases and then random
// command sequences under four idling phases on both channels.
// ----------------------------------------------------------------------------
module tb_software_timer_slots_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = stsu_pkg::NUM_SLOTS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int PHASE_ITEMS  = 72;

    // One expiry report: the slot index and the end-of-tick marker.
    typedef struct {
        logic [stsu_pkg::SLOT_W-1:0] fired_slot;
        logic                        last_of_tick;
    } expiry_t;

    // Slot table model plus the queue of expiries still to be reported.
    class expiry_scoreboard;
        bit                          active[SLOTS];
        logic [stsu_pkg::CNT_W-1:0]  remaining[SLOTS];
        logic [stsu_pkg::CNT_W-1:0]  reload[SLOTS];
        expiry_t                     pending_expiries[$];
        int                          mismatches;
        int                          commands;
        int                          ticks;
        int                          expiries;
        int                          most_in_tick;

        function new();
            foreach (active[i]) begin
                active[i]    = 1'b0;
                remaining[i] = '0;
                reload[i]    = '0;
            end
            mismatches   = 0;
            commands     = 0;
            ticks        = 0;
            expiries     = 0;
            most_in_tick = 0;
        endfunction

        // Update the table for an accepted item and queue its expiries.
        function void note_command(stsu_pkg::op_t op, logic [stsu_pkg::SLOT_W-1:0] slot,
                                   logic [stsu_pkg::CNT_W-1:0] interval, logic rpt);
            int fired[$];
            expiry_t item;
            commands++;
            case (op)
                stsu_pkg::OP_TICK: begin
                    ticks++;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (active[i]) begin
                            remaining[i] = remaining[i] - 1;
                            if (remaining[i] == '0) begin
                                if (reload[i] == '0)
                                    active[i] = 1'b0;
                                else
                                    remaining[i] = reload[i];
                                fired.push_back(i);
                            end
                        end
                    end
                    foreach (fired[k]) begin
                        item.fired_slot   = stsu_pkg::SLOT_W'(fired[k]);
                        item.last_of_tick = (k == fired.size() - 1);
                        pending_expiries.push_back(item);
                    end
                    if (fired.size() > most_in_tick)
                        most_in_tick = fired.size();
                end
                stsu_pkg::OP_SET: begin
                    // A running slot keeps its count and reload.
                    if (!active[slot]) begin
                        remaining[slot] = interval;
                        reload[slot]    = rpt ? interval : '0;
                    end
                end
                stsu_pkg::OP_ADD: active[slot] = 1'b1;
                stsu_pkg::OP_DEL: active[slot] = 1'b0;
                default: ;
            endcase
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Compare one reported expiry with the oldest queued one.
        function void check_expiry(logic [stsu_pkg::SLOT_W-1:0] slot, logic last);
            expiry_t want;
            if (pending_expiries.size() == 0) begin
                report_mismatch($sformatf("unexpected expiry: slot %0d last %0b",
                                          slot, last));
                return;
            end
            want = pending_expiries.pop_front();
            expiries++;
            if (want.fired_slot !== slot || want.last_of_tick !== last)
                report_mismatch($sformatf(
                    "expiry: expected slot %0d last %0b, got slot %0d last %0b",
                    want.fired_slot, want.last_of_tick, slot, last));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [stsu_pkg::S_TDATA_W-1:0] s_tdata;
    logic [stsu_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [stsu_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    expiry_scoreboard timers;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               idle_cycles;

    software_timer_slots_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: random stalls, changed at the falling edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each accepted expiry.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            timers.check_expiry(m_tdata[stsu_pkg::SLOT_W-1:0], m_tlast);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without progress", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command and hold it until the unit takes it.
    task automatic issue_command(stsu_pkg::op_t op, logic [stsu_pkg::SLOT_W-1:0] slot,
                                 logic [stsu_pkg::CNT_W-1:0] interval, logic rpt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, rpt, interval, slot};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        timers.note_command(op, slot, interval, rpt);
        @(negedge aclk);
    endtask

    // Hold the input back until every queued expiry has been reported.
    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (timers.pending_expiries.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly short countdowns so that slots fire often.
    function automatic logic [stsu_pkg::CNT_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 78)
            return '0;
        else if (r < 90)
            return $urandom_range(7, 40);
        else
            return $urandom;
    endfunction

    // Random command sequences: arming pairs, tick bursts, deletes and noise.
    task automatic random_phase(int items);
        int sent;
        int kind;
        int n;
        logic [stsu_pkg::SLOT_W-1:0] s;
        sent = 0;
        while (sent < items) begin
            kind = $urandom_range(99);
            s    = stsu_pkg::SLOT_W'($urandom_range(SLOTS - 1));
            if (kind < 40) begin
                issue_command(stsu_pkg::OP_SET, s, pick_interval(), 1'($urandom_range(1)));
                issue_command(stsu_pkg::OP_ADD, s, $urandom, 1'($urandom_range(1)));
                sent += 2;
            end else if (kind < 80) begin
                n = $urandom_range(1, 3);
                repeat (n)
                    issue_command(stsu_pkg::OP_TICK, stsu_pkg::SLOT_W'($urandom_range(15)),
                                  $urandom, 1'($urandom_range(1)));
                sent += n;
            end else if (kind < 90) begin
                issue_command(stsu_pkg::OP_DEL, s, $urandom, 1'($urandom_range(1)));
                sent++;
            end else begin
                issue_command(stsu_pkg::op_t'($urandom_range(3)),
                              stsu_pkg::SLOT_W'($urandom_range(15)), $urandom,
                              1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed cases, four random phases, drain.
    initial begin
        timers         = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = stsu_pkg::OP_TICK;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Tick with no slot running.
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        // One-shot slot fires once and then stays quiet.
        issue_command(stsu_pkg::OP_SET, 4'd0, 32'd1, 1'b0);
        issue_command(stsu_pkg::OP_ADD, 4'd0, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        // Periodic top slot; a set and an activate while it runs change nothing.
        issue_command(stsu_pkg::OP_SET, 4'd15, 32'd2, 1'b1);
        issue_command(stsu_pkg::OP_ADD, 4'd15, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_SET, 4'd15, 32'd7, 1'b0);
        issue_command(stsu_pkg::OP_ADD, 4'd15, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        // Zero countdowns wrap instead of firing, periodic or not.
        issue_command(stsu_pkg::OP_SET, 4'd3, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_SET, 4'd4, 32'd0, 1'b1);
        issue_command(stsu_pkg::OP_ADD, 4'd3, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_ADD, 4'd4, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_DEL, 4'd3, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_DEL, 4'd4, 32'd0, 1'b0);
        // Delete of an idle slot.
        issue_command(stsu_pkg::OP_DEL, 4'd9, 32'd0, 1'b0);
        // Several slots firing on the same tick, reported in slot order.
        issue_command(stsu_pkg::OP_SET, 4'd1, 32'd1, 1'b1);
        issue_command(stsu_pkg::OP_SET, 4'd2, 32'd1, 1'b0);
        issue_command(stsu_pkg::OP_ADD, 4'd1, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_ADD, 4'd2, 32'd0, 1'b0);
        issue_command(stsu_pkg::OP_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
        // Largest interval on an idle slot.
        issue_command(stsu_pkg::OP_SET, 4'd10, 32'hFFFF_FFFF, 1'b1);

        // No idling on either side.
        random_phase(PHASE_ITEMS);
        wait_for_drain();
        // Sender mostly idle.
        send_idle_pct = 88;
        random_phase(PHASE_ITEMS);
        wait_for_drain();
        // Receiver mostly stalled.
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        random_phase(PHASE_ITEMS);
        wait_for_drain();
        // Light idling on both sides.
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        random_phase(PHASE_ITEMS);

        s_tvalid = 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d commands including %0d ticks; %0d expiries compared.",
                 timers.commands, timers.ticks, timers.expiries);
        $display("Busiest tick reported %0d expiries; %0d mismatches counted.",
                 timers.most_in_tick, timers.mismatches);
        if (timers.mismatches == 0 && timers.pending_expiries.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
